>>> rtl/roll_rate_law_with_bank_protection_assert.svh
// Assertion macros for the roll rate law block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ROLL_RATE_LAW_WITH_BANK_PROTECTION_ASSERT_SVH
`define ROLL_RATE_LAW_WITH_BANK_PROTECTION_ASSERT_SVH

// cond must hold whenever trig holds
`define RRL_ASSERT_IMPL(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rrl assertion failed");

// trig is followed by cond, delayed by n
`define RRL_ASSERT_DELAY(lbl, trig, n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##n (cond)) \
        else $error("rrl assertion failed");

`endif

>>> rtl/rrl_pkg.sv
// Shared types and constants of the roll rate law block.
// No dependencies; imported by every rtl module.
package rrl_pkg;

    // register indexes on the config port
    localparam logic [2:0] REG_RATE_PER_DEFL = 3'd0;
    localparam logic [2:0] REG_RESTORING     = 3'd1;
    localparam logic [2:0] REG_CLAMP         = 3'd2;
    localparam logic [2:0] REG_MAX_BANK      = 3'd3;
    localparam logic [2:0] REG_NOMINAL       = 3'd4;
    localparam logic [2:0] REG_RATE_GAIN     = 3'd5;

    localparam logic [14:0] RST_RATE_PER_DEFL = 15'd1229;
    localparam logic [14:0] RST_RESTORING     = 15'd715;
    localparam logic [14:0] RST_CLAMP         = 15'd8579;
    localparam logic [14:0] RST_MAX_BANK      = 15'd9580;
    localparam logic [14:0] RST_NOMINAL       = 15'd4718;
    localparam logic [15:0] RST_RATE_GAIN     = 16'd2560;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_OVERBANK = 2'd1;
    localparam logic [1:0] MODE_LIMITED  = 2'd2;
    localparam logic [1:0] MODE_NOMINAL  = 2'd3;

    // divider: 15 quotient bits, 3 per stage
    localparam int DIV_BITS   = 15;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
    // two front stages, divider, three back stages
    localparam int LATENCY    = 5 + DIV_STAGES;

    typedef struct packed {
        logic signed [15:0] stick;
        logic signed [15:0] bank_angle;
        logic signed [15:0] body_roll_rate;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] aileron;
        logic signed [15:0] target_rate;
        logic [1:0]         protection_mode;
    } result_t;

    typedef struct packed {
        logic [14:0] rate_per_deflection;
        logic [14:0] restoring_rate;
        logic [14:0] clamp_angle;
        logic [14:0] max_bank;
        logic [14:0] nominal_bank;
        logic [15:0] rate_gain;
    } cfg_t;

    // decisions made up front that ride along with the divide
    typedef struct packed {
        logic signed [15:0] request;
        logic signed [15:0] body;
        logic               bank_pos;
        logic               bank_neg;
        logic               overbank;
        logic               in_zone;
        logic               centred;
    } side_t;

    typedef struct packed {
        logic        valid;
        logic [29:0] num;
        logic [14:0] den;
        side_t       side;
    } div_in_t;

    typedef struct packed {
        logic        valid;
        logic [14:0] quot;
        side_t       side;
    } div_out_t;

endpackage

>>> rtl/rrl_front.sv
// Front stages: stick scaling, bank magnitude, protection zone decode and
// the numerator product for the rate limit. Depends on rrl_pkg.
module rrl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rrl_pkg::frame_t frame,
    input  rrl_pkg::cfg_t   cfg,
    output rrl_pkg::div_in_t div_in
);
    import rrl_pkg::*;

    // stage A
    logic signed [15:0] rpd_s;
    logic signed [31:0] scaled;
    logic signed [31:0] rounded;
    logic signed [16:0] bank_ext;
    logic signed [16:0] bank_abs;

    logic               a_valid_reg;
    logic signed [15:0] a_req_reg, a_req_next;
    logic [15:0]        a_abank_reg, a_abank_next;
    logic               a_pos_reg, a_neg_reg, a_szero_reg;
    logic signed [15:0] a_body_reg;

    // stage B
    logic        overbank, above_clamp, above_nom, req_pos, req_neg, toward;
    logic [15:0] diff;
    logic        b_valid_reg;
    div_in_t     div_in_reg, div_in_next;

    assign rpd_s    = $signed({1'b0, cfg.rate_per_deflection});
    assign scaled   = rpd_s * frame.stick;
    assign rounded  = scaled + 32'sd16384;
    assign a_req_next = rounded[30:15];   // rounded to nearest (ties up), fits 16 bits

    assign bank_ext = {frame.bank_angle[15], frame.bank_angle};
    assign bank_abs = frame.bank_angle[15] ? -bank_ext : bank_ext;
    assign a_abank_next = bank_abs[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_req_reg   <= a_req_next;
        a_abank_reg <= a_abank_next;
        a_pos_reg   <= !frame.bank_angle[15] && (frame.bank_angle != 16'sd0);
        a_neg_reg   <= frame.bank_angle[15];
        a_szero_reg <= (frame.stick == 16'sd0);
        a_body_reg  <= frame.body_roll_rate;
    end

    always_comb
    begin
        overbank    = a_abank_reg >= {1'b0, cfg.max_bank};
        above_clamp = a_abank_reg >  {1'b0, cfg.clamp_angle};
        above_nom   = a_abank_reg >  {1'b0, cfg.nominal_bank};
        req_neg     = a_req_reg[15];
        req_pos     = !a_req_reg[15] && (a_req_reg != 16'sd0);
        // request rolls further into the bank
        toward      = (a_pos_reg && req_neg) || (a_neg_reg && req_pos) ||
                      (!a_pos_reg && !a_neg_reg && !req_pos && !req_neg);
        diff        = a_abank_reg - {1'b0, cfg.clamp_angle};

        div_in_next.valid = a_valid_reg;
        // only meaningful inside the zone, where diff and quotient fit 15 bits
        div_in_next.num   = {15'd0, diff[14:0]} * {15'd0, cfg.rate_per_deflection};
        div_in_next.den   = cfg.max_bank - cfg.clamp_angle;
        div_in_next.side.request  = a_req_reg;
        div_in_next.side.body     = a_body_reg;
        div_in_next.side.bank_pos = a_pos_reg;
        div_in_next.side.bank_neg = a_neg_reg;
        div_in_next.side.overbank = overbank;
        div_in_next.side.in_zone  = !overbank && above_clamp && toward && !a_szero_reg;
        div_in_next.side.centred  = above_nom && a_szero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= div_in_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        div_in_reg <= div_in_next;
    end

    // the valid bit comes from the reset flop
    always_comb
    begin
        div_in       = div_in_reg;
        div_in.valid = b_valid_reg;
    end

endmodule

>>> rtl/rrl_div.sv
// Pipelined restoring divider for the rate limit, DIV_STEPS quotient bits
// per stage. Depends on rrl_pkg.
module rrl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rrl_pkg::div_in_t  div_in,
    output rrl_pkg::div_out_t div_out
);
    import rrl_pkg::*;

    logic [DIV_STAGES-1:0] v_reg, v_next;
    logic [14:0] rem_reg [DIV_STAGES];
    logic [14:0] rem_next[DIV_STAGES];
    logic [14:0] low_reg [DIV_STAGES];
    logic [14:0] low_next[DIV_STAGES];
    logic [14:0] q_reg   [DIV_STAGES];
    logic [14:0] q_next  [DIV_STAGES];
    logic [14:0] den_reg [DIV_STAGES];
    logic [14:0] den_next[DIV_STAGES];
    side_t       side_reg [DIV_STAGES];
    side_t       side_next[DIV_STAGES];

    always_comb
    begin
        logic [14:0] rem;
        logic [14:0] low;
        logic [14:0] q;
        logic [14:0] d;
        logic [15:0] t;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                v_next[s]    = div_in.valid;
                rem          = div_in.num[29:15];
                low          = div_in.num[14:0];
                q            = 15'd0;
                d            = div_in.den;
                side_next[s] = div_in.side;
            end
            else
            begin
                v_next[s]    = v_reg[s-1];
                rem          = rem_reg[s-1];
                low          = low_reg[s-1];
                q            = q_reg[s-1];
                d            = den_reg[s-1];
                side_next[s] = side_reg[s-1];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                t = {rem, low[14]};
                if (t >= {1'b0, d})
                begin
                    rem = 15'(t - {1'b0, d});
                    q   = {q[13:0], 1'b1};
                end
                else
                begin
                    rem = t[14:0];
                    q   = {q[13:0], 1'b0};
                end
                low = {low[13:0], 1'b0};
            end
            rem_next[s] = rem;
            low_next[s] = low;
            q_next[s]   = q;
            den_next[s] = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s]  <= rem_next[s];
            low_reg[s]  <= low_next[s];
            q_reg[s]    <= q_next[s];
            den_reg[s]  <= den_next[s];
            side_reg[s] <= side_next[s];
        end
    end

    assign div_out.valid = v_reg[DIV_STAGES-1];
    assign div_out.quot  = q_reg[DIV_STAGES-1];
    assign div_out.side  = side_reg[DIV_STAGES-1];

endmodule

>>> rtl/rrl_back.sv
// Back stages: protection select, rate error, gain multiply, rounding and
// aileron saturation. Depends on rrl_pkg.
module rrl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rrl_pkg::div_out_t div_out,
    input  rrl_pkg::cfg_t     cfg,
    output logic              done,
    output rrl_pkg::result_t  result
);
    import rrl_pkg::*;

    // stage C
    logic signed [15:0] limit, mag, req, restore, target;
    logic [1:0]         mode;
    logic               c_valid_reg;
    logic signed [16:0] c_err_reg, c_err_next;
    logic signed [15:0] c_target_reg;
    logic [1:0]         c_mode_reg;

    // stage D
    logic signed [16:0] gain_s;
    logic               d_valid_reg;
    logic signed [33:0] d_prod_reg, d_prod_next;
    logic signed [15:0] d_target_reg;
    logic [1:0]         d_mode_reg;

    // stage E
    logic signed [34:0] rounded;
    logic signed [27:0] shifted;
    logic signed [15:0] ail;
    logic               done_reg;
    result_t            result_reg;

    always_comb
    begin
        req     = div_out.side.request;
        limit   = $signed({1'b0, cfg.rate_per_deflection}) - $signed({1'b0, div_out.quot});
        mag     = req[15] ? -req : req;
        if (div_out.side.bank_pos)
        begin
            restore = $signed({1'b0, cfg.restoring_rate});
        end
        else if (div_out.side.bank_neg)
        begin
            restore = -$signed({1'b0, cfg.restoring_rate});
        end
        else
        begin
            restore = 16'sd0;
        end

        if (div_out.side.overbank)
        begin
            target = restore;
            mode   = MODE_OVERBANK;
        end
        else if (div_out.side.in_zone)
        begin
            mode = MODE_LIMITED;
            if (mag > limit)
            begin
                target = req[15] ? -limit : limit;
            end
            else
            begin
                target = req;
            end
        end
        else if (div_out.side.centred)
        begin
            target = restore;
            mode   = MODE_NOMINAL;
        end
        else
        begin
            target = req;
            mode   = MODE_NONE;
        end
        c_err_next = {target[15], target} - {div_out.side.body[15], div_out.side.body};
    end

    assign gain_s      = $signed({1'b0, cfg.rate_gain});
    assign d_prod_next = c_err_reg * gain_s;

    always_comb
    begin
        rounded = {d_prod_reg[33], d_prod_reg} + 35'sd64;
        shifted = rounded[34:7];
        if (shifted > 28'sd16384)
        begin
            ail = 16'sd16384;
        end
        else if (shifted < -28'sd16384)
        begin
            ail = -16'sd16384;
        end
        else
        begin
            ail = shifted[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            c_valid_reg <= div_out.valid;
            d_valid_reg <= c_valid_reg;
            done_reg    <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_err_reg    <= c_err_next;
        c_target_reg <= target;
        c_mode_reg   <= mode;
        d_prod_reg   <= d_prod_next;
        d_target_reg <= c_target_reg;
        d_mode_reg   <= c_mode_reg;
        result_reg.aileron         <= ail;
        result_reg.target_rate     <= d_target_reg;
        result_reg.protection_mode <= d_mode_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/roll_rate_law_with_bank_protection.sv
// Top level of the roll rate law with bank protection: config registers,
// front, divider and back pipeline. Depends on rrl_pkg and the assert header.
//
//   channel  | signals                              | handshake
//   ---------+--------------------------------------+---------------------------
//   frame in | start, busy, frame                   | word taken when start & !busy
//   result   | done, result                         | word valid for one cycle
//   config   | cfg_valid, cfg_ready, cfg_index/data | write when valid & ready
//
// One frame per cycle; busy and cfg_ready are constant, nothing backs up.
// The pipeline, whose depth is LATENCY in rrl_pkg, has two front stages, five divider
// stages (15 quotient bits, three per stage) and three back stages.
// rst_n clears the valid bits and loads the config defaults.
// The receiver cannot stall, so no stage ever holds.
module roll_rate_law_with_bank_protection (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rrl_pkg::frame_t  frame,
    output logic             done,
    output rrl_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import rrl_pkg::*;

    cfg_t     cfg_reg;
    div_in_t  div_in;
    div_out_t div_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_per_deflection <= RST_RATE_PER_DEFL;
            cfg_reg.restoring_rate      <= RST_RESTORING;
            cfg_reg.clamp_angle         <= RST_CLAMP;
            cfg_reg.max_bank            <= RST_MAX_BANK;
            cfg_reg.nominal_bank        <= RST_NOMINAL;
            cfg_reg.rate_gain           <= RST_RATE_GAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RATE_PER_DEFL: cfg_reg.rate_per_deflection <= cfg_data[14:0];
                REG_RESTORING:     cfg_reg.restoring_rate      <= cfg_data[14:0];
                REG_CLAMP:         cfg_reg.clamp_angle         <= cfg_data[14:0];
                REG_MAX_BANK:      cfg_reg.max_bank            <= cfg_data[14:0];
                REG_NOMINAL:       cfg_reg.nominal_bank        <= cfg_data[14:0];
                REG_RATE_GAIN:     cfg_reg.rate_gain           <= cfg_data;
                default:           ;
            endcase
        end
    end

    rrl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start && !busy),
        .frame  (frame),
        .cfg    (cfg_reg),
        .div_in (div_in)
    );

    rrl_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_in  (div_in),
        .div_out (div_out)
    );

    rrl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_out (div_out),
        .cfg     (cfg_reg),
        .done    (done),
        .result  (result)
    );

`include "roll_rate_law_with_bank_protection_assert.svh"

    `RRL_ASSERT_DELAY(a_word_out, start && !busy, LATENCY, done)
    `RRL_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, LATENCY))
    `RRL_ASSERT_IMPL(a_ail_sat, done,
        result.aileron <= 16'sd16384 && result.aileron >= -16'sd16384)
    `RRL_ASSERT_IMPL(a_overbank_rate, done && result.protection_mode == MODE_OVERBANK,
        result.target_rate == $signed({1'b0, cfg_reg.restoring_rate}) ||
        result.target_rate == -$signed({1'b0, cfg_reg.restoring_rate}) ||
        result.target_rate == 16'sd0)

endmodule
